FILE: rtl/core/dpq_pkg.sv
// Shared package for the digit parity dual ring queue.
// Holds the ring geometry, character codes, outcome codes and helpers.
// No dependencies.
`timescale 1ns / 1ps

package dpq_pkg;

    localparam int DEPTH = 16;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = 4;
    localparam int DIGIT_W = 4;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_NINE = 8'd57;
    localparam logic [7:0] CHAR_LO_A = 8'd97;
    localparam logic [7:0] CHAR_LO_Z = 8'd122;
    localparam logic [7:0] CHAR_UP_A = 8'd65;
    localparam logic [7:0] CHAR_UP_Z = 8'd90;

    typedef enum logic [2:0] {
        OUT_IGNORED = 3'd0,
        OUT_PUSHED  = 3'd1,
        OUT_FULL    = 3'd2,
        OUT_POPPED  = 3'd3,
        OUT_EMPTY   = 3'd4
    } outcome_t;

    typedef logic [PTR_W-1:0] ptr_t;

    function automatic ptr_t ring_next(input ptr_t p);
        ptr_t r;
        if (p == PTR_LAST)
        begin
            r = '0;
        end
        else
        begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

    // Occupancy of a ring, reported in its low CNT_W bits.
    function automatic logic [CNT_W-1:0] ring_count(input ptr_t head, input ptr_t tail);
        logic [PTR_W:0]       diff;
        logic [PTR_W+CNT_W:0] wide;
        if (tail >= head)
        begin
            diff = {1'b0, tail} - {1'b0, head};
        end
        else
        begin
            diff = {1'b0, tail} + (PTR_W+1)'(DEPTH) - {1'b0, head};
        end
        wide = {{CNT_W{1'b0}}, diff};
        return wide[CNT_W-1:0];
    endfunction

endpackage

FILE: rtl/core/dpq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dpq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/digit_parity_dual_ring_queue.sv
// Digit parity dual ring queue: classifies one ASCII byte per transaction, pushes digits
// on an even or odd ring and pops them on letters. Depends on dpq_pkg and dpq_ram.
// Result: an accepted transaction passes through the fetch stage and then the output register.
// Flow: input waits while the RAM read is in flight and while an untaken result is held.
// Reset: all ring pointers go to zero and no result is pending; RAM contents are not
// cleared and no clearing pass is run.
`timescale 1ns / 1ps

module digit_parity_dual_ring_queue (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] outcome,
    output logic       queue_sel,
    output logic [3:0] popped_digit,
    output logic [3:0] even_count,
    output logic [3:0] odd_count
);

    dpq_pkg::ptr_t even_head_reg, even_head_next;
    dpq_pkg::ptr_t even_tail_reg, even_tail_next;
    dpq_pkg::ptr_t odd_head_reg, odd_head_next;
    dpq_pkg::ptr_t odd_tail_reg, odd_tail_next;

    // Fetch stage: the transaction waits here for the RAM read data.
    logic              fetch_reg;
    dpq_pkg::outcome_t f_outcome_reg, f_outcome_next;
    logic              f_sel_reg, f_sel_next;
    logic [3:0]        f_ecnt_reg;
    logic [3:0]        f_ocnt_reg;

    // Output register.
    logic              out_valid_reg;
    dpq_pkg::outcome_t o_outcome_reg;
    logic              o_sel_reg;
    logic [3:0]        o_digit_reg;
    logic [3:0]        o_ecnt_reg;
    logic [3:0]        o_ocnt_reg;

    logic       accept;
    logic       even_we, odd_we;
    logic [3:0] digit_val;
    logic [3:0] even_rdata, odd_rdata;
    logic [3:0] fetch_digit;
    logic       is_digit, is_lower, is_upper;

    // Input waits while the fetch stage is full or the output register holds an untaken result.
    assign in_ready = !fetch_reg && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign is_digit  = (char_in >= dpq_pkg::CHAR_ZERO) && (char_in <= dpq_pkg::CHAR_NINE);
    assign is_lower  = (char_in >= dpq_pkg::CHAR_LO_A) && (char_in <= dpq_pkg::CHAR_LO_Z);
    assign is_upper  = (char_in >= dpq_pkg::CHAR_UP_A) && (char_in <= dpq_pkg::CHAR_UP_Z);
    assign digit_val = 4'(char_in - dpq_pkg::CHAR_ZERO);

    always_comb
    begin
        even_head_next = even_head_reg;
        even_tail_next = even_tail_reg;
        odd_head_next  = odd_head_reg;
        odd_tail_next  = odd_tail_reg;
        f_outcome_next = dpq_pkg::OUT_IGNORED;
        f_sel_next     = 1'b0;
        even_we        = 1'b0;
        odd_we         = 1'b0;
        if (is_digit)
        begin
            // The character code of zero is even, so bit zero gives the parity.
            if (!char_in[0])
            begin
                if (dpq_pkg::ring_next(even_tail_reg) == even_head_reg)
                begin
                    f_outcome_next = dpq_pkg::OUT_FULL;
                end
                else
                begin
                    f_outcome_next = dpq_pkg::OUT_PUSHED;
                    even_we        = accept;
                    if (accept)
                    begin
                        even_tail_next = dpq_pkg::ring_next(even_tail_reg);
                    end
                end
            end
            else
            begin
                f_sel_next = 1'b1;
                if (dpq_pkg::ring_next(odd_tail_reg) == odd_head_reg)
                begin
                    f_outcome_next = dpq_pkg::OUT_FULL;
                end
                else
                begin
                    f_outcome_next = dpq_pkg::OUT_PUSHED;
                    odd_we         = accept;
                    if (accept)
                    begin
                        odd_tail_next = dpq_pkg::ring_next(odd_tail_reg);
                    end
                end
            end
        end
        else if (is_lower)
        begin
            if (even_head_reg == even_tail_reg)
            begin
                f_outcome_next = dpq_pkg::OUT_EMPTY;
            end
            else
            begin
                f_outcome_next = dpq_pkg::OUT_POPPED;
                if (accept)
                begin
                    even_head_next = dpq_pkg::ring_next(even_head_reg);
                end
            end
        end
        else if (is_upper)
        begin
            f_sel_next = 1'b1;
            if (odd_head_reg == odd_tail_reg)
            begin
                f_outcome_next = dpq_pkg::OUT_EMPTY;
            end
            else
            begin
                f_outcome_next = dpq_pkg::OUT_POPPED;
                if (accept)
                begin
                    odd_head_next = dpq_pkg::ring_next(odd_head_reg);
                end
            end
        end
    end

    // Both rings read at their head every cycle; the data sampled at the
    // accepting edge belongs to the head before it advances.
    dpq_ram #(
        .WIDTH(dpq_pkg::DIGIT_W),
        .DEPTH(dpq_pkg::DEPTH)
    ) u_even_ram (
        .clk  (clk),
        .we   (even_we),
        .waddr(even_tail_reg),
        .wdata(digit_val),
        .raddr(even_head_reg),
        .rdata(even_rdata)
    );

    dpq_ram #(
        .WIDTH(dpq_pkg::DIGIT_W),
        .DEPTH(dpq_pkg::DEPTH)
    ) u_odd_ram (
        .clk  (clk),
        .we   (odd_we),
        .waddr(odd_tail_reg),
        .wdata(digit_val),
        .raddr(odd_head_reg),
        .rdata(odd_rdata)
    );

    always_comb
    begin
        if (f_outcome_reg == dpq_pkg::OUT_POPPED)
        begin
            fetch_digit = f_sel_reg ? odd_rdata : even_rdata;
        end
        else
        begin
            fetch_digit = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            even_head_reg <= '0;
            even_tail_reg <= '0;
            odd_head_reg  <= '0;
            odd_tail_reg  <= '0;
            fetch_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            even_head_reg <= even_head_next;
            even_tail_reg <= even_tail_next;
            odd_head_reg  <= odd_head_next;
            odd_tail_reg  <= odd_tail_next;
            fetch_reg     <= accept;
            if (fetch_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_outcome_reg <= f_outcome_next;
            f_sel_reg     <= f_sel_next;
            f_ecnt_reg    <= dpq_pkg::ring_count(even_head_next, even_tail_next);
            f_ocnt_reg    <= dpq_pkg::ring_count(odd_head_next, odd_tail_next);
        end
        if (fetch_reg)
        begin
            o_outcome_reg <= f_outcome_reg;
            o_sel_reg     <= f_sel_reg;
            o_digit_reg   <= fetch_digit;
            o_ecnt_reg    <= f_ecnt_reg;
            o_ocnt_reg    <= f_ocnt_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign outcome      = o_outcome_reg;
    assign queue_sel    = o_sel_reg;
    assign popped_digit = o_digit_reg;
    assign even_count   = o_ecnt_reg;
    assign odd_count    = o_ocnt_reg;

endmodule
